// ===== src/pnt_pkg.sv =====
// ----------------------------------------------------------------------------
// pnt_pkg: shared types and constants for the proximity neighbor table
// Holds event codes, register indexes, reset values and the struct types
// passed between the table memory, the compare unit and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pnt_pkg;

   // Field widths
   localparam int unsigned NODE_W    = 16;
   localparam int unsigned RSSI_W    = 8;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned EV_W      = 3;
   localparam int unsigned CNT_OUT_W = 7;
   localparam int unsigned LIMIT_W   = 7;
   localparam int unsigned TMO_W     = 16;
   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 56;

   // Counts are compared at this width (covers table depths up to 256)
   localparam int unsigned CNT_CMP_W = 9;

   // Leaves reported per sweep, and the counter for them
   localparam int unsigned MAX_RESULTS = 64;
   localparam int unsigned LEAVE_W     = $clog2(MAX_RESULTS);

   // Configuration port
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_THR_CROWDED   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THR_BUSY      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THR_QUIET     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CROWD_LIMIT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BUSY_LIMIT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LEAVE_TIMEOUT = 3'd5;

   // Register reset values
   localparam logic signed [RSSI_W-1:0] THR_CROWDED_RST   = -8'sd75;
   localparam logic signed [RSSI_W-1:0] THR_BUSY_RST      = -8'sd70;
   localparam logic signed [RSSI_W-1:0] THR_QUIET_RST     = -8'sd65;
   localparam logic [LIMIT_W-1:0]       CROWD_LIMIT_RST   = 7'd10;
   localparam logic [LIMIT_W-1:0]       BUSY_LIMIT_RST    = 7'd5;
   localparam logic [TMO_W-1:0]         LEAVE_TIMEOUT_RST = 16'd30;

   // Item kinds
   localparam logic FUNC_BEACON = 1'b0;
   localparam logic FUNC_SWEEP  = 1'b1;

   // Event codes
   localparam logic [EV_W-1:0] EV_WEAK    = 3'd0;
   localparam logic [EV_W-1:0] EV_DETECT  = 3'd1;
   localparam logic [EV_W-1:0] EV_RETURN  = 3'd2;
   localparam logic [EV_W-1:0] EV_REFRESH = 3'd3;
   localparam logic [EV_W-1:0] EV_LEAVE   = 3'd4;
   localparam logic [EV_W-1:0] EV_FULL    = 3'd5;
   localparam logic [EV_W-1:0] EV_NONE    = 3'd6;

   // One table entry as read from memory
   typedef struct packed {
      logic [NODE_W-1:0] id;
      logic [TIME_W-1:0] first;
      logic [TIME_W-1:0] last;
   } entry_type;

   // Table write controls
   typedef struct packed {
      logic              we_id;
      logic              we_first;
      logic              we_last;
      logic              pres_set;
      logic              pres_clr;
      logic [NODE_W-1:0] id;
      logic [TIME_W-1:0] first;
      logic [TIME_W-1:0] last;
   } tbl_wr_type;

   // Compare unit results
   typedef struct packed {
      logic              id_eq;
      logic              expired;
      logic              rssi_gt;
      logic [TIME_W-1:0] tip;
   } cmp_res_type;

   // Low bits of a count for the result field
   function automatic logic [CNT_OUT_W-1:0] cnt_lo7(input logic [CNT_CMP_W-1:0] v);
      return v[CNT_OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/pnt_table.sv =====
// ----------------------------------------------------------------------------
// pnt_table: neighbor table storage
// Id, first-seen and last-seen memories with one write port and one
// registered read port, plus present flags in flops cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pnt_table #(
   parameter int unsigned TABLE_ENTRIES = 64,
   localparam int unsigned IW = $clog2(TABLE_ENTRIES)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [IW-1:0]       rd_idx,
   output      pnt_pkg::entry_type  rd_data,
   input  wire logic [IW-1:0]       wr_idx,
   input  wire pnt_pkg::tbl_wr_type wr,
   input  wire logic [IW-1:0]       pres_idx,
   output      logic                pres_bit
);

   logic [pnt_pkg::NODE_W-1:0] id_mem    [TABLE_ENTRIES];
   logic [pnt_pkg::TIME_W-1:0] first_mem [TABLE_ENTRIES];
   logic [pnt_pkg::TIME_W-1:0] last_mem  [TABLE_ENTRIES];

   pnt_pkg::entry_type         rd_data_ff;
   logic [TABLE_ENTRIES-1:0]   present_ff;

   // Write the memories, register the read data
   always_ff @(posedge clock) begin
      if (wr.we_id) begin
         id_mem[wr_idx] <= wr.id;
      end
      if (wr.we_first) begin
         first_mem[wr_idx] <= wr.first;
      end
      if (wr.we_last) begin
         last_mem[wr_idx] <= wr.last;
      end
      if (rd_en) begin
         rd_data_ff.id    <= id_mem[rd_idx];
         rd_data_ff.first <= first_mem[rd_idx];
         rd_data_ff.last  <= last_mem[rd_idx];
      end
   end

   // Set and clear present flags
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else if (wr.pres_set) begin
         present_ff[wr_idx] <= 1'b1;
      end else if (wr.pres_clr) begin
         present_ff[wr_idx] <= 1'b0;
      end
   end

   assign rd_data  = rd_data_ff;
   assign pres_bit = present_ff[pres_idx];

endmodule

`default_nettype wire

// ===== src/pnt_cmp.sv =====
// ----------------------------------------------------------------------------
// pnt_cmp: shared compare unit
// Matches the entry id, tests entry age against the timeout, forms the time
// in proximity and tests the RSSI against the selected threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module pnt_cmp (
   input  wire pnt_pkg::entry_type                entry,
   input  wire logic [pnt_pkg::NODE_W-1:0]        node_id,
   input  wire logic [pnt_pkg::TIME_W-1:0]        now,
   input  wire logic [pnt_pkg::TMO_W-1:0]         timeout,
   input  wire logic signed [pnt_pkg::RSSI_W-1:0] rssi,
   input  wire logic signed [pnt_pkg::RSSI_W-1:0] thr,
   output      pnt_pkg::cmp_res_type              res
);

   logic [pnt_pkg::TIME_W-1:0] age;

   // Age modulo 2^32, then compare against the zero-extended timeout
   always_comb begin
      age         = now - entry.last;
      res.id_eq   = (entry.id == node_id);
      res.expired = (age > pnt_pkg::TIME_W'(timeout));
      res.tip     = entry.last - entry.first;
      res.rssi_gt = (rssi > thr);
   end

endmodule

`default_nettype wire

// ===== src/proximity_neighbor_table.sv =====
// ----------------------------------------------------------------------------
// proximity_neighbor_table: neighbor table with detect, return and leave
// Beacons add, revive or refresh entries above an RSSI threshold chosen
// from the proximity count; sweeps age out present entries, reporting up to 64.
// ----------------------------------------------------------------------------
// Order: a weak beacon goes from the threshold to the result state; others
//   scan filled entries through the shared unit, then a beacon takes the hit
//   or miss state; back-pressure holds the result and a sweep's final state.
// Throughput: one item at a time, next transfer in the cycle after the result
//   is loaded; the scan reads one entry per cycle unless a sweep stalls.
// Reset: synchronous, clears counts, present flags and the sequencer and
//   loads register defaults; no clearing pass is run over the memories.
`default_nettype none

module proximity_neighbor_table #(
   parameter int unsigned TABLE_ENTRIES = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input item stream
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // node_id[15:0], rssi[23:16], timestamp[55:24]
   input  wire logic [pnt_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func[0]
   input  wire logic                              req_tuser,
   // Result stream
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // event_node[15:0], dwell_time[47:16], proximity_count[54:48], pad[55]
   output      logic [pnt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // event_res[2:0]
   output      logic [pnt_pkg::EV_W-1:0]          rsp_tuser,
   output      logic                              rsp_tlast,
   // Configuration write channel
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [pnt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pnt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned IW = $clog2(TABLE_ENTRIES);
   localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_THR    = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_HIT    = 3'd3;
   localparam logic [2:0] S_MISS   = 3'd4;
   localparam logic [2:0] S_RESULT = 3'd5;
   localparam logic [2:0] S_FIN    = 3'd6;

   // Configuration registers
   logic signed [pnt_pkg::RSSI_W-1:0] thr_crowded_ff, thr_busy_ff, thr_quiet_ff;
   logic [pnt_pkg::LIMIT_W-1:0]       crowd_limit_ff, busy_limit_ff;
   logic [pnt_pkg::TMO_W-1:0]         leave_timeout_ff;

   // Sequencer state
   logic [2:0]                        state_ff, state_in;
   logic [CW-1:0]                     entry_count_ff, entry_count_in;
   logic [CW-1:0]                     near_count_ff, near_count_in;
   logic [CW-1:0]                     rd_idx_ff, rd_idx_in;
   logic [IW-1:0]                     ev_idx_ff, ev_idx_in;
   logic                              ev_vld_ff, ev_vld_in;
   logic [pnt_pkg::LEAVE_W-1:0]       leave_cnt_ff, leave_cnt_in;
   logic [pnt_pkg::EV_W-1:0]          res_ev_ff, res_ev_in;

   // Item registers
   logic                              func_ff;
   logic [pnt_pkg::NODE_W-1:0]        node_ff;
   logic signed [pnt_pkg::RSSI_W-1:0] rssi_ff;
   logic [pnt_pkg::TIME_W-1:0]        now_ff;
   logic                              item_load;

   // Pending leave result
   logic                              pend_vld_ff, pend_vld_in;
   logic [pnt_pkg::NODE_W-1:0]        pend_node_ff, pend_node_in;
   logic [pnt_pkg::TIME_W-1:0]        pend_tip_ff, pend_tip_in;
   logic [pnt_pkg::CNT_OUT_W-1:0]     pend_cnt_ff, pend_cnt_in;

   // Output register
   logic                              rsp_valid_ff;
   logic [pnt_pkg::EV_W-1:0]          rsp_ev_ff, out_ev;
   logic [pnt_pkg::NODE_W-1:0]        rsp_node_ff, out_node;
   logic [pnt_pkg::TIME_W-1:0]        rsp_tip_ff, out_tip;
   logic [pnt_pkg::CNT_OUT_W-1:0]     rsp_cnt_ff, out_cnt;
   logic                              rsp_last_ff, out_last;
   logic                              out_load;
   logic                              out_free;

   // Table and compare unit connections
   logic                              rd_en;
   pnt_pkg::entry_type                rd_data;
   logic [IW-1:0]                     wr_idx;
   pnt_pkg::tbl_wr_type               tbl_wr;
   logic                              pres_bit;
   logic signed [pnt_pkg::RSSI_W-1:0] thr_sel;
   pnt_pkg::cmp_res_type              cmp_res;

   // Scan helpers
   logic                              want_issue;
   logic                              leave_hit;
   logic                              stall;
   logic [CW-1:0]                     near_dec;
   logic [pnt_pkg::CNT_CMP_W-1:0]     near_wide;

   pnt_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_idx   (rd_idx_ff[IW-1:0]),
      .rd_data  (rd_data),
      .wr_idx   (wr_idx),
      .wr       (tbl_wr),
      .pres_idx (ev_idx_ff),
      .pres_bit (pres_bit)
   );

   pnt_cmp u_cmp (
      .entry   (rd_data),
      .node_id (node_ff),
      .now     (now_ff),
      .timeout (leave_timeout_ff),
      .rssi    (rssi_ff),
      .thr     (thr_sel),
      .res     (cmp_res)
   );

   // Select the threshold from the proximity count
   always_comb begin
      near_wide = pnt_pkg::CNT_CMP_W'(near_count_ff);
      priority if (near_wide > pnt_pkg::CNT_CMP_W'(crowd_limit_ff)) begin
         thr_sel = thr_crowded_ff;
      end else if (near_wide > pnt_pkg::CNT_CMP_W'(busy_limit_ff)) begin
         thr_sel = thr_busy_ff;
      end else begin
         thr_sel = thr_quiet_ff;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign want_issue = (rd_idx_ff < entry_count_ff);
   assign leave_hit  = (func_ff == pnt_pkg::FUNC_SWEEP) && ev_vld_ff && pres_bit &&
                       cmp_res.expired;
   assign stall      = leave_hit && pend_vld_ff && !out_free;
   assign near_dec   = (near_count_ff != '0) ? near_count_ff - CW'(1) : near_count_ff;

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      near_count_in  = near_count_ff;
      rd_idx_in      = rd_idx_ff;
      ev_idx_in      = ev_idx_ff;
      ev_vld_in      = ev_vld_ff;
      leave_cnt_in   = leave_cnt_ff;
      res_ev_in      = res_ev_ff;
      pend_vld_in    = pend_vld_ff;
      pend_node_in   = pend_node_ff;
      pend_tip_in    = pend_tip_ff;
      pend_cnt_in    = pend_cnt_ff;
      item_load      = 1'b0;
      rd_en          = 1'b0;
      wr_idx         = ev_idx_ff;
      tbl_wr         = '0;
      out_load       = 1'b0;
      out_ev         = pnt_pkg::EV_NONE;
      out_node       = '0;
      out_tip        = '0;
      out_cnt        = pnt_pkg::cnt_lo7(pnt_pkg::CNT_CMP_W'(near_count_ff));
      out_last       = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               item_load = 1'b1;
               state_in  = S_THR;
            end
         end

         // Start a scan, or drop a weak beacon
         S_THR: begin
            rd_idx_in    = '0;
            ev_vld_in    = 1'b0;
            leave_cnt_in = '0;
            pend_vld_in  = 1'b0;
            if (func_ff == pnt_pkg::FUNC_BEACON && !cmp_res.rssi_gt) begin
               res_ev_in = pnt_pkg::EV_WEAK;
               state_in  = S_RESULT;
            end else begin
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            if (func_ff == pnt_pkg::FUNC_BEACON) begin
               // Search filled entries, lowest match wins
               if (ev_vld_ff && cmp_res.id_eq) begin
                  state_in = S_HIT;
               end else if (want_issue) begin
                  rd_en     = 1'b1;
                  rd_idx_in = rd_idx_ff + CW'(1);
                  ev_idx_in = rd_idx_ff[IW-1:0];
                  ev_vld_in = 1'b1;
               end else begin
                  ev_vld_in = 1'b0;
                  if (!ev_vld_ff) begin
                     state_in = S_MISS;
                  end
               end
            end else if (!stall) begin
               // Age out expired present entries
               if (leave_hit) begin
                  tbl_wr.we_first = 1'b1;
                  tbl_wr.we_last  = 1'b1;
                  tbl_wr.pres_clr = 1'b1;
                  near_count_in   = near_dec;
                  leave_cnt_in    = leave_cnt_ff + pnt_pkg::LEAVE_W'(1);
                  if (pend_vld_ff) begin
                     out_load = 1'b1;
                     out_ev   = pnt_pkg::EV_LEAVE;
                     out_node = pend_node_ff;
                     out_tip  = pend_tip_ff;
                     out_cnt  = pend_cnt_ff;
                     out_last = 1'b0;
                  end
                  pend_vld_in  = 1'b1;
                  pend_node_in = rd_data.id;
                  pend_tip_in  = cmp_res.tip;
                  pend_cnt_in  = pnt_pkg::cnt_lo7(pnt_pkg::CNT_CMP_W'(near_dec));
               end
               if (leave_hit &&
                   leave_cnt_ff == pnt_pkg::LEAVE_W'(pnt_pkg::MAX_RESULTS - 1)) begin
                  ev_vld_in = 1'b0;
                  state_in  = S_FIN;
               end else if (want_issue) begin
                  rd_en     = 1'b1;
                  rd_idx_in = rd_idx_ff + CW'(1);
                  ev_idx_in = rd_idx_ff[IW-1:0];
                  ev_vld_in = 1'b1;
               end else begin
                  ev_vld_in = 1'b0;
                  if (!ev_vld_ff) begin
                     state_in = S_FIN;
                  end
               end
            end
         end

         // Known node: revive or refresh
         S_HIT: begin
            tbl_wr.we_last = 1'b1;
            tbl_wr.last    = now_ff;
            if (!pres_bit) begin
               tbl_wr.we_first = 1'b1;
               tbl_wr.first    = now_ff;
               tbl_wr.pres_set = 1'b1;
               near_count_in   = near_count_ff + CW'(1);
               res_ev_in       = pnt_pkg::EV_RETURN;
            end else begin
               res_ev_in = pnt_pkg::EV_REFRESH;
            end
            state_in = S_RESULT;
         end

         // New node: append, or flag a full table
         S_MISS: begin
            if (entry_count_ff >= CW'(TABLE_ENTRIES)) begin
               res_ev_in = pnt_pkg::EV_FULL;
            end else begin
               wr_idx          = entry_count_ff[IW-1:0];
               tbl_wr.we_id    = 1'b1;
               tbl_wr.we_first = 1'b1;
               tbl_wr.we_last  = 1'b1;
               tbl_wr.pres_set = 1'b1;
               tbl_wr.id       = node_ff;
               tbl_wr.first    = now_ff;
               tbl_wr.last     = now_ff;
               entry_count_in  = entry_count_ff + CW'(1);
               near_count_in   = near_count_ff + CW'(1);
               res_ev_in       = pnt_pkg::EV_DETECT;
            end
            state_in = S_RESULT;
         end

         S_RESULT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_ev   = res_ev_ff;
               out_node = node_ff;
               state_in = S_IDLE;
            end
         end

         // Close the sweep with the last leave or a none event
         S_FIN: begin
            if (out_free) begin
               out_load = 1'b1;
               if (pend_vld_ff) begin
                  out_ev   = pnt_pkg::EV_LEAVE;
                  out_node = pend_node_ff;
                  out_tip  = pend_tip_ff;
                  out_cnt  = pend_cnt_ff;
               end
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= '0;
         near_count_ff  <= '0;
         ev_vld_ff      <= 1'b0;
         pend_vld_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         near_count_ff  <= near_count_in;
         ev_vld_ff      <= ev_vld_in;
         pend_vld_ff    <= pend_vld_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      ev_idx_ff    <= ev_idx_in;
      leave_cnt_ff <= leave_cnt_in;
      res_ev_ff    <= res_ev_in;
      pend_node_ff <= pend_node_in;
      pend_tip_ff  <= pend_tip_in;
      pend_cnt_ff  <= pend_cnt_in;
      if (item_load) begin
         func_ff <= req_tuser;
         node_ff <= req_tdata[15:0];
         rssi_ff <= req_tdata[23:16];
         now_ff  <= req_tdata[55:24];
      end
      if (out_load) begin
         rsp_ev_ff   <= out_ev;
         rsp_node_ff <= out_node;
         rsp_tip_ff  <= out_tip;
         rsp_cnt_ff  <= out_cnt;
         rsp_last_ff <= out_last;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_crowded_ff   <= pnt_pkg::THR_CROWDED_RST;
         thr_busy_ff      <= pnt_pkg::THR_BUSY_RST;
         thr_quiet_ff     <= pnt_pkg::THR_QUIET_RST;
         crowd_limit_ff   <= pnt_pkg::CROWD_LIMIT_RST;
         busy_limit_ff    <= pnt_pkg::BUSY_LIMIT_RST;
         leave_timeout_ff <= pnt_pkg::LEAVE_TIMEOUT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            pnt_pkg::REG_THR_CROWDED:   thr_crowded_ff   <= csr_wdata[7:0];
            pnt_pkg::REG_THR_BUSY:      thr_busy_ff      <= csr_wdata[7:0];
            pnt_pkg::REG_THR_QUIET:     thr_quiet_ff     <= csr_wdata[7:0];
            pnt_pkg::REG_CROWD_LIMIT:   crowd_limit_ff   <= csr_wdata[6:0];
            pnt_pkg::REG_BUSY_LIMIT:    busy_limit_ff    <= csr_wdata[6:0];
            pnt_pkg::REG_LEAVE_TIMEOUT: leave_timeout_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ev_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, rsp_cnt_ff, rsp_tip_ff, rsp_node_ff};

`ifndef SYNTHESIS
   a_near_le_entries: assert property (@(posedge clock) disable iff (reset)
      near_count_ff <= entry_count_ff)
      else $error("proximity count exceeds filled entries");

   a_entries_le_depth: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CW'(TABLE_ENTRIES))
      else $error("entry count beyond table depth");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new item taken while one is in work");

   a_tip_only_on_leave: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ev_ff != pnt_pkg::EV_LEAVE) |-> (rsp_tip_ff == '0))
      else $error("time in proximity set on a non-leave event");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && ev_vld_ff) |-> (CW'(ev_idx_ff) < entry_count_ff))
      else $error("scan reads an unfilled entry");
`endif

endmodule

`default_nettype wire

// ===== tb/proximity_neighbor_table_tb.sv =====
// ----------------------------------------------------------------------------
// proximity_neighbor_table_tb: self-checking bench for the neighbor table
// Drives beacon and sweep items over the request stream and checks every
// event on the response stream against a scoreboard that tracks its own copy
// of the table, counts and registers. Runs a directed opening, then random
// traffic under several register settings with random gaps on both streams,
// a long response hold-off and a full drain in mid-run.
// ----------------------------------------------------------------------------
module proximity_neighbor_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_ENTRIES   = 64;
   localparam int ID_POOL         = 100;
   localparam int SETTLE_CYCLES   = 80;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int STALL_LIMIT     = 4000;

   typedef struct packed {
      logic [pnt_pkg::EV_W-1:0]      ev;
      logic [pnt_pkg::NODE_W-1:0]    node;
      logic [pnt_pkg::TIME_W-1:0]    tip;
      logic [pnt_pkg::CNT_OUT_W-1:0] cnt;
      logic                          last;
   } neighbor_event_type;

   // Tracks the neighbor table and holds the events it is due to report
   class neighbor_scoreboard;
      logic [pnt_pkg::NODE_W-1:0] slot_id[TABLE_ENTRIES];
      logic [pnt_pkg::TIME_W-1:0] slot_first[TABLE_ENTRIES];
      logic [pnt_pkg::TIME_W-1:0] slot_last[TABLE_ENTRIES];
      bit                slot_present[TABLE_ENTRIES];
      int unsigned       filled;
      int unsigned       near;
      logic signed [pnt_pkg::RSSI_W-1:0] thr_crowded;
      logic signed [pnt_pkg::RSSI_W-1:0] thr_busy;
      logic signed [pnt_pkg::RSSI_W-1:0] thr_quiet;
      logic [pnt_pkg::LIMIT_W-1:0] crowd_limit;
      logic [pnt_pkg::LIMIT_W-1:0] busy_limit;
      logic [pnt_pkg::TMO_W-1:0]   leave_timeout;
      neighbor_event_type expected_events[$];
      int unsigned        mismatches;

      function new();
         thr_crowded   = pnt_pkg::THR_CROWDED_RST;
         thr_busy      = pnt_pkg::THR_BUSY_RST;
         thr_quiet     = pnt_pkg::THR_QUIET_RST;
         crowd_limit   = pnt_pkg::CROWD_LIMIT_RST;
         busy_limit    = pnt_pkg::BUSY_LIMIT_RST;
         leave_timeout = pnt_pkg::LEAVE_TIMEOUT_RST;
         filled        = 0;
         near          = 0;
         mismatches    = 0;
         foreach (slot_present[i]) slot_present[i] = 1'b0;
      endfunction

      function void set_reg(logic [pnt_pkg::CSR_IDX_W-1:0] idx,
                            logic [pnt_pkg::CSR_DATA_W-1:0] val);
         unique case (idx)
            pnt_pkg::REG_THR_CROWDED:   thr_crowded   = val[pnt_pkg::RSSI_W-1:0];
            pnt_pkg::REG_THR_BUSY:      thr_busy      = val[pnt_pkg::RSSI_W-1:0];
            pnt_pkg::REG_THR_QUIET:     thr_quiet     = val[pnt_pkg::RSSI_W-1:0];
            pnt_pkg::REG_CROWD_LIMIT:   crowd_limit   = val[pnt_pkg::LIMIT_W-1:0];
            pnt_pkg::REG_BUSY_LIMIT:    busy_limit    = val[pnt_pkg::LIMIT_W-1:0];
            pnt_pkg::REG_LEAVE_TIMEOUT: leave_timeout = val[pnt_pkg::TMO_W-1:0];
            default: ;
         endcase
      endfunction

      // Event as reported after the state change it describes
      function neighbor_event_type make_event(logic [pnt_pkg::EV_W-1:0] ev,
                                              logic [pnt_pkg::NODE_W-1:0] node,
                                              logic [pnt_pkg::TIME_W-1:0] tip, logic fin);
         neighbor_event_type e;
         e.ev   = ev;
         e.node = node;
         e.tip  = tip;
         e.cnt  = near[pnt_pkg::CNT_OUT_W-1:0];
         e.last = fin;
         return e;
      endfunction

      // Apply one accepted item and queue the events it must produce
      function void note_item(logic func, logic [pnt_pkg::NODE_W-1:0] node,
                              logic signed [pnt_pkg::RSSI_W-1:0] rssi,
                              logic [pnt_pkg::TIME_W-1:0] now);
         logic signed [pnt_pkg::RSSI_W-1:0] thr;
         int unsigned     hit;
         logic [pnt_pkg::TIME_W-1:0] age;
         logic [pnt_pkg::TIME_W-1:0] tip;
         neighbor_event_type batch[$];
         if (func == pnt_pkg::FUNC_BEACON) begin
            if (near > crowd_limit) thr = thr_crowded;
            else if (near > busy_limit) thr = thr_busy;
            else thr = thr_quiet;
            if (rssi <= thr) begin
               expected_events.push_back(make_event(pnt_pkg::EV_WEAK, node, '0, 1'b1));
               return;
            end
            // lowest filled slot with this id wins
            hit = filled;
            for (int i = 0; i < filled; i++) begin
               if (slot_id[i] == node) begin
                  hit = i;
                  break;
               end
            end
            if (hit == filled) begin
               if (filled == TABLE_ENTRIES) begin
                  expected_events.push_back(make_event(pnt_pkg::EV_FULL, node, '0, 1'b1));
               end else begin
                  slot_id[filled]      = node;
                  slot_first[filled]   = now;
                  slot_last[filled]    = now;
                  slot_present[filled] = 1'b1;
                  filled++;
                  near++;
                  expected_events.push_back(make_event(pnt_pkg::EV_DETECT, node, '0, 1'b1));
               end
            end else if (!slot_present[hit]) begin
               slot_first[hit]   = now;
               slot_last[hit]    = now;
               slot_present[hit] = 1'b1;
               near++;
               expected_events.push_back(make_event(pnt_pkg::EV_RETURN, node, '0, 1'b1));
            end else begin
               slot_last[hit] = now;
               expected_events.push_back(make_event(pnt_pkg::EV_REFRESH, node, '0, 1'b1));
            end
         end else begin
            // age out present slots in index order
            for (int i = 0; i < filled && batch.size() < pnt_pkg::MAX_RESULTS; i++) begin
               age = now - slot_last[i];
               if (slot_present[i] && age > leave_timeout) begin
                  tip = slot_last[i] - slot_first[i];
                  slot_present[i] = 1'b0;
                  slot_first[i]   = '0;
                  slot_last[i]    = '0;
                  if (near > 0) near--;
                  batch.push_back(make_event(pnt_pkg::EV_LEAVE, slot_id[i], tip, 1'b0));
               end
            end
            if (batch.size() == 0) begin
               expected_events.push_back(make_event(pnt_pkg::EV_NONE, '0, '0, 1'b1));
            end else begin
               batch[batch.size()-1].last = 1'b1;
               foreach (batch[k]) expected_events.push_back(batch[k]);
            end
         end
      endfunction

      // Compare one received event with the oldest one due
      function void check_event(neighbor_event_type got);
         neighbor_event_type want;
         if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t unexpected event: ev=%0d node=%h tip=%h cnt=%0d last=%b",
                        $realtime, got.ev, got.node, got.tip, got.cnt, got.last);
            return;
         end
         want = expected_events.pop_front();
         if (got.ev !== want.ev || got.node !== want.node || got.tip !== want.tip ||
             got.cnt !== want.cnt || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t event mismatch: want ev=%0d node=%h tip=%h cnt=%0d last=%b, %s",
                        $realtime, want.ev, want.node, want.tip, want.cnt, want.last,
                        $sformatf("got ev=%0d node=%h tip=%h cnt=%0d last=%b",
                                  got.ev, got.node, got.tip, got.cnt, got.last));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [pnt_pkg::REQ_DATA_W-1:0] req_tdata;
   logic req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [pnt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [pnt_pkg::EV_W-1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_valid;
   logic csr_ready;
   logic [pnt_pkg::CSR_IDX_W-1:0] csr_index;
   logic [pnt_pkg::CSR_DATA_W-1:0] csr_wdata;

   neighbor_scoreboard sb;
   int          idle_pct;
   bit          hold_rsp;
   int unsigned stall_cycles;
   logic [pnt_pkg::TIME_W-1:0] now;
   logic [pnt_pkg::NODE_W-1:0] id_pool[ID_POOL];
   int          next_new;

   proximity_neighbor_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(3, 1);
      if (r < 95) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Watch both streams: note accepted items, check returned events
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_item(req_tuser, req_tdata[15:0], req_tdata[23:16], req_tdata[55:24]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_event(neighbor_event_type'({rsp_tuser, rsp_tdata[15:0], rsp_tdata[47:16],
                                              rsp_tdata[54:48], rsp_tlast}));
   end

   // Abort when no transfer happens on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Response pacing: random stalls, plus one long hold-off on request
   initial begin : rsp_pacing
      int stall;
      rsp_tready = 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_pct != 0 && $urandom_range(99) < idle_pct) stall = gap_len();
         end
      end
   end

   // Offer one item and hold it until the transfer
   task automatic send_item(logic func, logic [pnt_pkg::NODE_W-1:0] node,
                            logic [pnt_pkg::RSSI_W-1:0] rssi,
                            logic [pnt_pkg::TIME_W-1:0] ts);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {ts, rssi, node};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering, wait for every due event, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all six registers back to back; only called with the block idle
   task automatic program_regs(logic signed [pnt_pkg::RSSI_W-1:0] crowded,
                               logic signed [pnt_pkg::RSSI_W-1:0] busy,
                               logic signed [pnt_pkg::RSSI_W-1:0] quiet,
                               logic [pnt_pkg::LIMIT_W-1:0] crowd_lim,
                               logic [pnt_pkg::LIMIT_W-1:0] busy_lim,
                               logic [pnt_pkg::TMO_W-1:0] tmo);
      logic [pnt_pkg::CSR_DATA_W-1:0] vals[6];
      logic [pnt_pkg::CSR_IDX_W-1:0]  idxs[6];
      vals = '{{{8{crowded[7]}}, crowded}, {{8{busy[7]}}, busy}, {{8{quiet[7]}}, quiet},
               {9'd0, crowd_lim}, {9'd0, busy_lim}, tmo};
      idxs = '{pnt_pkg::REG_THR_CROWDED, pnt_pkg::REG_THR_BUSY, pnt_pkg::REG_THR_QUIET,
               pnt_pkg::REG_CROWD_LIMIT, pnt_pkg::REG_BUSY_LIMIT, pnt_pkg::REG_LEAVE_TIMEOUT};
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idxs[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.set_reg(idxs[i], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // Random traffic: beacons from a growing id pool, sweeps, drifting time
   task automatic run_traffic(int items, int new_pct, int sweep_pct);
      int r;
      logic [pnt_pkg::NODE_W-1:0] node;
      logic [pnt_pkg::RSSI_W-1:0] rssi;
      for (int n = 0; n < items; n++) begin
         r = $urandom_range(99);
         if (r < 60) now = now + $urandom_range(5);
         else if (r < 85) now = now + $urandom_range(40, 6);
         else if (r < 95) now = now + $urandom_range(70000);
         else now = $urandom;
         if ($urandom_range(99) < sweep_pct) begin
            send_item(pnt_pkg::FUNC_SWEEP, pnt_pkg::NODE_W'($urandom),
                      pnt_pkg::RSSI_W'($urandom), now);
         end else begin
            if (next_new == 0 || $urandom_range(99) < new_pct) begin
               if (next_new < ID_POOL) begin
                  node = id_pool[next_new];
                  next_new++;
               end else begin
                  node = pnt_pkg::NODE_W'($urandom);
               end
            end else begin
               node = id_pool[$urandom_range(next_new - 1)];
            end
            if ($urandom_range(99) < 75) rssi = pnt_pkg::RSSI_W'($urandom_range(177) - 50);
            else rssi = pnt_pkg::RSSI_W'($urandom);
            send_item(pnt_pkg::FUNC_BEACON, node, rssi, now);
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = pnt_pkg::FUNC_BEACON;
      csr_valid  = 1'b0;
      csr_index  = pnt_pkg::REG_THR_CROWDED;
      csr_wdata  = '0;
      idle_pct   = 25;
      hold_rsp   = 1'b0;
      now        = 1000;
      next_new   = 0;
      sb = new();
      foreach (id_pool[i]) id_pool[i] = pnt_pkg::NODE_W'($urandom);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening under reset register values
      send_item(pnt_pkg::FUNC_SWEEP, 16'h0000, 8'h00, 32'h0000_0000);      // empty table
      send_item(pnt_pkg::FUNC_BEACON, 16'h0000, -8'sd65, 32'd100);         // equal to threshold
      send_item(pnt_pkg::FUNC_BEACON, 16'h0000, -8'sd64, 32'd100);         // detect
      send_item(pnt_pkg::FUNC_BEACON, 16'hFFFF, 8'sd127, 32'hFFFF_FFF0);   // detect
      send_item(pnt_pkg::FUNC_BEACON, 16'hFFFF, -8'sd128, 32'hFFFF_FFF0);  // weakest
      send_item(pnt_pkg::FUNC_BEACON, 16'h0000, 8'sd0, 32'd110);           // refresh
      send_item(pnt_pkg::FUNC_SWEEP, 16'hFFFF, 8'hFF, 32'd140);            // wrapped age leaves
      send_item(pnt_pkg::FUNC_SWEEP, 16'h0000, 8'h00, 32'd141);            // one past timeout
      send_item(pnt_pkg::FUNC_BEACON, 16'hFFFF, -8'sd1, 32'hFFFF_FFFF);    // return
      send_item(pnt_pkg::FUNC_SWEEP, 16'h0000, 8'h00, 32'd20);             // wrapped, not aged
      // Grow the count through the busy and crowded thresholds
      for (int k = 0; k < 10; k++) begin
         if (k == 5)
            send_item(pnt_pkg::FUNC_BEACON, 16'(16'h0100 + k), -8'sd70, 32'd30);
         send_item(pnt_pkg::FUNC_BEACON, 16'(16'h0100 + k), -8'sd60, 32'd30);
      end
      send_item(pnt_pkg::FUNC_BEACON, 16'h1234, -8'sd75, 32'd30);          // crowded, equal
      send_item(pnt_pkg::FUNC_BEACON, 16'h1234, -8'sd74, 32'd30);
      send_item(pnt_pkg::FUNC_SWEEP, 16'h0000, 8'h00, 32'd100);            // everyone leaves
      drain();

      // Moderate thresholds, small id set
      program_regs(-8'sd40, -8'sd20, 8'sd0, 7'd8, 7'd3, 16'd40);
      run_traffic(40, 20, 15);
      drain();

      // Extremes: quiet rejects all, longest timeout, crowded never applies
      program_regs(8'sd127, -8'sd128, 8'sd127, 7'd64, 7'd0, 16'hFFFF);
      run_traffic(15, 20, 15);
      drain();

      // Opposite extremes, zero timeout, no idling, long response hold-off
      program_regs(-8'sd128, 8'sd127, -8'sd128, 7'd0, 7'd64, 16'd0);
      idle_pct = 0;
      hold_rsp = 1'b1;
      run_traffic(40, 10, 20);
      drain();

      // Fill the table, pause halfway until all events are back
      program_regs(-8'sd90, -8'sd80, -8'sd70, 7'd20, 7'd10, 16'd25);
      idle_pct = 25;
      run_traffic(55, 60, 12);
      drain();
      run_traffic(55, 60, 12);
      now = now + 70000;
      send_item(pnt_pkg::FUNC_SWEEP, 16'h0000, 8'h00, now);
      drain();

      if (sb.mismatches == 0 && sb.expected_events.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/pnt_pkg.sv
src/pnt_table.sv
src/pnt_cmp.sv
src/proximity_neighbor_table.sv
tb/proximity_neighbor_table_tb.sv
